[rtl/core/wca_pkg.sv]
`default_nettype none
package wca_pkg;

  localparam int NAT_W   = 16;
  localparam int LEFT_W  = 17;
  localparam int ROW_W   = 16;
  localparam int GAP_W   = 10;
  localparam int MIN_W   = 10;
  localparam int ALIGN_W = 2;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam int MAX_CELLS_DEF = 16;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CELL_GAP  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MIN_WIDTH = 2'd2;
  localparam logic [CIDX_W-1:0] REG_ALIGN     = 2'd3;

  // alignment modes
  localparam logic [ALIGN_W-1:0] ALIGN_EQUAL  = 2'd0;
  localparam logic [ALIGN_W-1:0] ALIGN_LEFT   = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd2;
  localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 2'd3;

endpackage
`default_nettype wire

[rtl/core/weighted_cell_apportioner.sv]
`default_nettype none
// Weighted cell apportioner. Natural widths stream in one per transaction on
// the slave side (tlast closes the row, as does reaching MAX_CELLS cells);
// the block then sends one transaction per cell with its left offset and
// width. While a row is being computed or sent, s_axis_tready is low. Rows
// whose natural widths fit and that are not in equal mode skip the split and
// go straight to output. Split rows run passes of the weighted split: each
// pass totals the free weights, then runs per unpinned cell a bit-serial
// multiply and a bit-serial divide of the 32 + log2(MAX_CELLS) bit product;
// a pinned cell skips both. The number of passes is one plus the number of
// passes that pin new cells, at most n + 1.
module weighted_cell_apportioner #(
  parameter int MAX_CELLS = wca_pkg::MAX_CELLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [wca_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [wca_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // natural_width
  input  wire logic                         s_axis_tlast,  // last_cell
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // cell_left, cell_width, zero pad
  output logic                              m_axis_tlast   // last_result
);
  import wca_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int RUN_W = NAT_W + IDX_W;
  localparam int PRD_W = ROW_W + RUN_W;
  localparam int GPS_W = CNT_W + GAP_W;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PREP    = 4'd1;
  localparam logic [3:0] ST_DECIDE  = 4'd2;
  localparam logic [3:0] ST_TOT_RD  = 4'd3;
  localparam logic [3:0] ST_TOT_DAT = 4'd4;
  localparam logic [3:0] ST_SPL_RD  = 4'd5;
  localparam logic [3:0] ST_SPL_DAT = 4'd6;
  localparam logic [3:0] ST_MUL     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_PASS    = 4'd9;
  localparam logic [3:0] ST_OUT_RD  = 4'd10;
  localparam logic [3:0] ST_OUT_LD  = 4'd11;

  // configuration
  logic [ROW_W-1:0]   row_width;
  logic [GAP_W-1:0]   cell_gap;
  logic [MIN_W-1:0]   min_cell_width;
  logic [ALIGN_W-1:0] align_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= '0;
      cell_gap       <= '0;
      min_cell_width <= '0;
      align_mode     <= ALIGN_EQUAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width      <= cfg_data[ROW_W-1:0];
        REG_CELL_GAP:  cell_gap       <= cfg_data[GAP_W-1:0];
        REG_MIN_WIDTH: min_cell_width <= cfg_data[MIN_W-1:0];
        REG_ALIGN:     align_mode     <= cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [3:0]           state;
  logic [CNT_W-1:0]     cell_count;
  logic [CNT_W-1:0]     idx;
  logic [RUN_W-1:0]     total_nat;
  logic [GPS_W-1:0]     gaps;
  logic [ROW_W-1:0]     room;
  logic [MIN_W-1:0]     floor_w;
  logic                 use_nat;
  logic                 equal;
  logic [LEFT_W-1:0]    left;
  logic [MAX_CELLS-1:0] pinned_flags;
  logic [CNT_W-1:0]     pinned_n;
  logic [CNT_W-1:0]     added;
  logic [RUN_W-1:0]     total;
  logic [RUN_W-1:0]     run;
  logic [ROW_W-1:0]     share;
  logic [NAT_W-1:0]     edge_r;

  // weight and width stores
  logic [NAT_W-1:0] weight_store [MAX_CELLS];
  logic [NAT_W-1:0] width_store  [MAX_CELLS];
  logic [NAT_W-1:0] weight_rd;
  logic [NAT_W-1:0] width_rd;
  logic             wr_en;
  logic [NAT_W-1:0] wr_data;

  logic in_take;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (in_take) begin
      weight_store[cell_count[IDX_W-1:0]] <= s_axis_tdata;
    end
    weight_rd <= weight_store[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      width_store[idx[IDX_W-1:0]] <= wr_data;
    end
    width_rd <= width_store[idx[IDX_W-1:0]];
  end

  // serial arithmetic units
  logic             mul_start;
  logic             mul_done;
  logic [PRD_W-1:0] product;
  logic             div_start;
  logic             div_done;
  logic [PRD_W-1:0] quot;

  // row-level arithmetic, all narrow
  logic [GPS_W-1:0]     gaps_calc;
  logic [GPS_W-1:0]     floor_need;
  logic [RUN_W+1:0]     nat_need;
  logic [RUN_W+1:0]     spare;
  logic [GPS_W-1:0]     pin_room;
  logic [RUN_W-1:0]     wv;
  logic [RUN_W-1:0]     run_next;
  logic [NAT_W-1:0]     next_edge;
  logic [NAT_W-1:0]     split_w;
  logic                 cur_pinned;
  logic                 cnt_full;
  logic                 out_load;

  wca_mult #(.A_W(ROW_W), .B_W(RUN_W)) u_mult (
    .clk(clk), .rst(rst), .start(mul_start), .a(share), .b(run_next),
    .done(mul_done), .product(product)
  );

  wca_divider #(.N_W(PRD_W), .D_W(RUN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(product), .denom(total),
    .done(div_done), .quot(quot)
  );

  assign gaps_calc  = (cell_count - 1'b1) * cell_gap;
  assign floor_need = cell_count * min_cell_width;
  assign nat_need   = (RUN_W+2)'(total_nat) + (RUN_W+2)'(gaps);
  assign spare      = (RUN_W+2)'(row_width) - nat_need;
  assign pin_room   = pinned_n * floor_w;
  assign wv         = equal ? RUN_W'(1) : RUN_W'(weight_rd);
  assign run_next   = run + wv;
  assign next_edge  = quot[NAT_W-1:0];
  assign split_w    = next_edge - edge_r;
  assign cur_pinned = pinned_flags[idx[IDX_W-1:0]];
  assign cnt_full   = (cell_count + 1'b1) == CNT_W'(MAX_CELLS);
  assign out_load   = (state == ST_OUT_LD) && (!m_axis_tvalid || m_axis_tready);

  // width store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (state == ST_SPL_DAT) begin
      if (cur_pinned) begin
        wr_en   = 1'b1;
        wr_data = NAT_W'(floor_w);
      end else if (total == '0) begin
        wr_en = 1'b1;
      end
    end else if (state == ST_DIV && div_done) begin
      wr_en   = 1'b1;
      wr_data = split_w;
    end
  end

  assign mul_start = (state == ST_SPL_DAT) && !cur_pinned && (total != '0);
  assign div_start = (state == ST_MUL) && mul_done;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cell_count    <= '0;
      total_nat     <= '0;
      idx           <= '0;
      pinned_flags  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            cell_count <= cell_count + 1'b1;
            total_nat  <= total_nat + RUN_W'(s_axis_tdata);
            if (s_axis_tlast || cnt_full) begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          gaps  <= gaps_calc;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          room         <= (row_width >= ROW_W'(gaps)) ? row_width - ROW_W'(gaps) : '0;
          pinned_flags <= '0;
          pinned_n     <= '0;
          idx          <= '0;
          total        <= '0;
          left         <= '0;
          equal        <= (align_mode == ALIGN_EQUAL);
          if (align_mode == ALIGN_EQUAL || nat_need > (RUN_W+2)'(row_width)) begin
            use_nat <= 1'b0;
            state   <= ST_TOT_RD;
          end else begin
            use_nat <= 1'b1;
            if (align_mode == ALIGN_CENTER) begin
              left <= LEFT_W'(spare >> 1);
            end else if (align_mode == ALIGN_RIGHT) begin
              left <= LEFT_W'(spare);
            end
            state <= ST_OUT_RD;
          end
        end
        ST_TOT_RD: begin
          // drop the floor when the row cannot hold it
          if (ROW_W'(floor_need) > room) begin
            floor_w <= '0;
          end else begin
            floor_w <= min_cell_width;
          end
          state <= ST_TOT_DAT;
        end
        ST_TOT_DAT: begin
          if (!cur_pinned) begin
            total <= total + wv;
          end
          if (idx + 1'b1 == cell_count) begin
            idx    <= '0;
            share  <= (room >= ROW_W'(pin_room)) ? room - ROW_W'(pin_room) : '0;
            run    <= '0;
            edge_r <= '0;
            added  <= '0;
            state  <= ST_SPL_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_TOT_RD;
          end
        end
        ST_SPL_RD: begin
          state <= ST_SPL_DAT;
        end
        ST_SPL_DAT: begin
          if (cur_pinned) begin
            state <= ST_PASS;
          end else if (total != '0) begin
            run   <= run_next;
            state <= ST_MUL;
          end else begin
            if (floor_w != '0) begin
              pinned_flags[idx[IDX_W-1:0]] <= 1'b1;
              added <= added + 1'b1;
            end
            state <= ST_PASS;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            edge_r <= next_edge;
            if (split_w < NAT_W'(floor_w)) begin
              pinned_flags[idx[IDX_W-1:0]] <= 1'b1;
              added <= added + 1'b1;
            end
            state <= ST_PASS;
          end
        end
        ST_PASS: begin
          // advance to the next cell, or close the pass
          if (idx + 1'b1 != cell_count) begin
            idx   <= idx + 1'b1;
            state <= ST_SPL_RD;
          end else if (added == '0) begin
            idx   <= '0;
            state <= ST_OUT_RD;
          end else begin
            pinned_n <= pinned_n + added;
            idx      <= '0;
            total    <= '0;
            state    <= ST_TOT_RD;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, (use_nat ? weight_rd : width_rd), left};
            m_axis_tlast  <= (idx + 1'b1 == cell_count);
            left <= left + LEFT_W'(use_nat ? weight_rd : width_rd) + LEFT_W'(cell_gap);
            if (idx + 1'b1 == cell_count) begin
              idx        <= '0;
              cell_count <= '0;
              total_nat  <= '0;
              state      <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/wca_mult.sv]
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module wca_mult #(
  parameter int A_W = 16,
  parameter int B_W = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      product
);
  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(A_W + 1);

  logic [A_W-1:0] mplier;
  logic [P_W-1:0] mcand;
  logic [C_W-1:0] cnt;
  logic           busy;

  // accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= '0;
      mplier  <= a;
      mcand   <= {{A_W{1'b0}}, b};
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
      cnt    <= cnt + 1'b1;
      if (cnt == C_W'(A_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/wca_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module wca_divider #(
  parameter int N_W = 36,
  parameter int D_W = 20
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] numer,
  input  wire logic [D_W-1:0] denom,
  output logic                done,
  output logic [N_W-1:0]      quot
);
  localparam int C_W = $clog2(N_W + 1);

  logic [D_W:0]   rem;
  logic [D_W:0]   trial;
  logic [D_W-1:0] den;
  logic [C_W-1:0] cnt;
  logic           busy;

  assign trial = {rem[D_W-1:0], quot[N_W-1]};

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      den  <= denom;
      quot <= numer;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[N_W-2:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[N_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == C_W'(N_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
